>>> rtl/trah_pkg.sv
// Shared constants, register indexes and controller/datapath bundles.
package trah_pkg;

  localparam int TEMP_W           = 17;
  localparam int CODE_W           = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int BUFFER_DEPTH_DEF = 32;

  localparam logic [TEMP_W-1:0] MIN_TEMP_RST = 17'd512;
  localparam logic [TEMP_W-1:0] MAX_TEMP_RST = 17'd38400;

  localparam logic [8:0] SCALE_MUL = 9'd328;
  localparam int         BAND      = 102;
  localparam int         HALF_DEG  = 128;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_TEMP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TEMP = 2'd1;

  typedef struct packed {
    logic capture;
    logic convert;
    logic store;
    logic scan_clear;
    logic scan_issue;
    logic div_start;
    logic div_step;
    logic finish;
  } trah_cmd_t;

  typedef struct packed {
    logic report;
    logic scan_last;
    logic count_zero;
    logic div_last;
    logic out_free;
  } trah_sts_t;

endpackage

>>> rtl/trah_if.sv
// Channel interfaces: sample input, averaged result output, register write.
interface trah_in_if import trah_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] adc_code;
  logic              report;
  modport source (output valid, output adc_code, output report, input ready);
  modport sink   (input valid, input adc_code, input report, output ready);
endinterface

interface trah_out_if import trah_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TEMP_W-1:0] avg_temp;
  logic              avg_valid;
  modport source (output valid, output avg_temp, output avg_valid, input ready);
  modport sink   (input valid, input avg_temp, input avg_valid, output ready);
endinterface

interface trah_cfg_if import trah_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TEMP_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/trah_ctrl.sv
// Controller state machine: sequences convert, store, scan, divide and report.
module trah_ctrl import trah_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  trah_sts_t sts,
  output trah_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_STORE = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        cmd.convert = 1'b1;
        state_next  = S_STORE;
      end
      S_STORE: begin
        cmd.store      = 1'b1;
        cmd.scan_clear = 1'b1;
        state_next     = sts.report ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last read accumulates here
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.count_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/trah_dpath.sv
// Datapath: scaling, range registers, sample ring, accumulator, divider, hysteresis.
module trah_dpath import trah_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  trah_cmd_t            cmd,
  output trah_sts_t            sts,
  input  logic [CODE_W-1:0]    in_code,
  input  logic                 in_report,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TEMP_W-1:0]    cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [TEMP_W-1:0]    out_avg_temp,
  output logic                 out_avg_valid
);

  localparam int PTR_W  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
  localparam int SUM_W  = TEMP_W + CNT_W;
  localparam int DC_W   = $clog2(SUM_W);
  localparam int PROD_W = CODE_W + 9;

  logic [TEMP_W-1:0] min_temp;
  logic [TEMP_W-1:0] max_temp;
  logic [CODE_W-1:0] code;
  logic              rep;
  logic [TEMP_W-1:0] temp;

  logic [TEMP_W-1:0]       mem [BUFFER_DEPTH];
  logic [BUFFER_DEPTH-1:0] vld;
  logic [PTR_W-1:0]        wr_pos;
  logic [PTR_W-1:0]        rd_idx;
  logic [TEMP_W-1:0]       rd_mem;
  logic                    rd_ok;
  logic                    rd_pend;
  logic [TEMP_W-1:0]       rd_val;

  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] dq;
  logic [CNT_W-1:0] rem;
  logic [DC_W-1:0]  dcnt;
  logic [CNT_W:0]   trial;
  logic             q_bit;

  logic [TEMP_W-1:0] last_reported;
  logic [PROD_W-1:0] prod;
  logic [TEMP_W:0]   avg18;
  logic [TEMP_W:0]   last18;
  logic [TEMP_W:0]   round_up;
  logic              go_up;
  logic              go_dn;

  function automatic logic in_range(input logic [TEMP_W-1:0] x,
                                    input logic [TEMP_W-1:0] lo,
                                    input logic [TEMP_W-1:0] hi);
    return (x >= lo) && (x <= hi);
  endfunction

  // range registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_temp <= MIN_TEMP_RST;
      max_temp <= MAX_TEMP_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_MIN_TEMP) begin
        min_temp <= cfg_data;
      end else if (cfg_index == REG_MAX_TEMP) begin
        max_temp <= cfg_data;
      end
    end
  end

  // input capture and Q9.8 conversion
  assign prod = PROD_W'(code) * PROD_W'(SCALE_MUL);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      code <= in_code;
      rep  <= in_report;
    end
    if (cmd.convert) begin
      temp <= prod[PROD_W-1:8];
    end
  end

  // sample ring
  always_ff @(posedge clk) begin
    if (cmd.store && in_range(temp, min_temp, max_temp)) begin
      mem[wr_pos] <= temp;
    end
    if (cmd.scan_issue) begin
      rd_mem <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      wr_pos <= '0;
    end else if (cmd.store && in_range(temp, min_temp, max_temp)) begin
      vld[wr_pos] <= 1'b1;
      wr_pos      <= (wr_pos == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : wr_pos + 1'b1;
    end
  end

  // entries never written read as their cleared value
  assign rd_val = rd_ok ? rd_mem : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      rd_idx <= '0;
      sum    <= '0;
      cnt    <= '0;
    end else begin
      if (cmd.scan_issue) begin
        rd_ok  <= vld[rd_idx];
        rd_idx <= rd_idx + 1'b1;
      end
      if (rd_pend && in_range(rd_val, min_temp, max_temp)) begin
        sum <= sum + SUM_W'(rd_val);
        cnt <= cnt + 1'b1;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  assign trial = {rem, dq[SUM_W-1]};
  assign q_bit = trial >= {1'b0, cnt};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq   <= sum;
      rem  <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      rem  <= q_bit ? CNT_W'(trial - {1'b0, cnt}) : CNT_W'(trial);
      dq   <= {dq[SUM_W-2:0], q_bit};
      dcnt <= dcnt + 1'b1;
    end
  end

  // hysteresis against the last reported value
  assign avg18    = {1'b0, dq[TEMP_W-1:0]};
  assign last18   = {1'b0, last_reported};
  assign go_up    = avg18 > (last18 + (TEMP_W+1)'(BAND));
  assign go_dn    = (avg18 + (TEMP_W+1)'(BAND)) < last18;
  assign round_up = (avg18 + (TEMP_W+1)'(HALF_DEG - 1)) & ~((TEMP_W+1)'(HALF_DEG - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      last_reported <= '0;
      out_valid     <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
      if (cnt == '0) begin
        out_avg_temp  <= '0;
        out_avg_valid <= 1'b0;
      end else begin
        out_avg_valid <= 1'b1;
        priority if (go_up) begin
          last_reported <= round_up[TEMP_W-1:0];
          out_avg_temp  <= round_up[TEMP_W-1:0];
        end else if (go_dn) begin
          last_reported <= avg18[TEMP_W-1:0] & ~(TEMP_W'(HALF_DEG - 1));
          out_avg_temp  <= avg18[TEMP_W-1:0] & ~(TEMP_W'(HALF_DEG - 1));
        end else begin
          out_avg_temp <= last_reported;
        end
      end
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.report     = rep;
  assign sts.scan_last  = rd_idx == PTR_W'(BUFFER_DEPTH - 1);
  assign sts.count_zero = cnt == '0;
  assign sts.div_last   = dcnt == DC_W'(SUM_W - 1);
  assign sts.out_free   = !out_valid || out_ready;

endmodule

>>> rtl/temp_ring_average_hysteresis_unit.sv
// Top level: sensor samples in, hysteresis-filtered ring average out.
//
// in_ch carries one ADC code and a report flag per transaction. The code is
// scaled to Q9.8 degrees; if it falls inside [min_temp, max_temp] it goes into
// a BUFFER_DEPTH-entry ring. With report set, every in-range entry is summed,
// floor-divided by the count and filtered with a 0.4 degree band against the
// last reported value; one transaction then appears on out_ch.
// cfg writes min_temp (index 0) or max_temp (index 1); cfg is always ready. It is
// to be written while the block is idle; the block itself does not enforce this.
// Timing: a sample without report passes the convert and store states before
// ready returns. For a report the scan reads one ring entry per cycle from the
// single-read-port sample memory and the restoring divider yields one quotient
// bit per cycle (a count of zero skips the divide).
// The result sits in an output register, so the next sample is taken while
// it waits; a second report stalls in its last cycle until out_ch is free.
// Reset: ranges 512 and 38400, ring cleared, write position and last value 0.
module temp_ring_average_hysteresis_unit import trah_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  trah_in_if.sink    in_ch,
  trah_out_if.source out_ch,
  trah_cfg_if.sink   cfg
);

  trah_cmd_t cmd;
  trah_sts_t sts;

  assign cfg.ready = 1'b1;

  trah_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  trah_dpath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_code       (in_ch.adc_code),
    .in_report     (in_ch.report),
    .cfg_we        (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_avg_temp  (out_ch.avg_temp),
    .out_avg_valid (out_ch.avg_valid)
  );

`ifndef ASSERT_OFF
  // an accepted sample always leaves the idle state
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input still ready after accepting a transaction");

  // an error result carries a zero temperature
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.avg_valid |-> out_ch.avg_temp == '0)
    else $error("invalid result with nonzero temperature");

  // every reported value is a multiple of half a degree
  a_half_degree: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.avg_valid |-> out_ch.avg_temp[6:0] == 7'd0)
    else $error("reported temperature not on a half-degree step");
`endif

endmodule

>>> dv/tb_temp_ring_average_hysteresis_unit.sv
// Self-checking testbench for the ring-buffer temperature averager with hysteresis.
module tb_temp_ring_average_hysteresis_unit;
  import trah_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH     = BUFFER_DEPTH_DEF;
  localparam int TEMP_TOP       = 83967;
  localparam int SETTLE_CYCLES  = 80;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES  = 7;
  localparam int PHASE_ITEMS    = 245;
  localparam int LONG_HOLD      = 400;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;
  localparam logic [31:0]          HALF_MASK    = ~(32'(HALF_DEG) - 32'd1);

  typedef enum int {WIN_RESET, WIN_FULL, WIN_NARROW, WIN_INVERTED, WIN_WIDE} window_kind_t;

  typedef struct packed {
    logic [TEMP_W-1:0] avg_temp;
    logic              avg_valid;
  } avg_result_t;

  logic clk;
  logic rst;

  trah_in_if  in_ch();
  trah_out_if out_ch();
  trah_cfg_if cfg_ch();

  temp_ring_average_hysteresis_unit #(.BUFFER_DEPTH(RING_DEPTH)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  // predictor state
  logic [TEMP_W-1:0] min_lim;
  logic [TEMP_W-1:0] max_lim;
  logic [TEMP_W-1:0] ring [RING_DEPTH];
  int                wr_pos;
  logic [TEMP_W-1:0] last_avg;
  avg_result_t       avg_expected[$];

  int  n_samples;
  int  n_results;
  int  n_invalid;
  int  n_writes;
  int  n_mismatch;
  int  idle_cycles;
  int  long_hold;
  bit  in_gaps_on;
  bit  out_gaps_on;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(30, 150);
  endfunction

  function automatic bit in_window(logic [TEMP_W-1:0] t);
    return t >= min_lim && t <= max_lim;
  endfunction

  // Store the sample if it lands in the window, then on report compute the
  // filtered average and queue it.
  function automatic void model_sample(logic [CODE_W-1:0] code, logic rep);
    logic [TEMP_W-1:0] t;
    logic [31:0]       sum;
    logic [31:0]       cnt;
    logic [31:0]       mean;
    avg_result_t       res;
    t = TEMP_W'((32'(code) * 32'(SCALE_MUL)) >> 8);
    if (in_window(t)) begin
      ring[wr_pos] = t;
      wr_pos = (wr_pos == RING_DEPTH - 1) ? 0 : wr_pos + 1;
    end
    if (!rep) return;
    sum = '0;
    cnt = '0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      if (in_window(ring[i])) begin
        sum += 32'(ring[i]);
        cnt++;
      end
    end
    if (cnt == 0) begin
      res.avg_temp  = '0;
      res.avg_valid = 1'b0;
    end else begin
      mean = sum / cnt;
      if (mean > 32'(last_avg) + 32'(BAND))
        last_avg = TEMP_W'((mean + 32'(HALF_DEG - 1)) & HALF_MASK);
      else if (mean + 32'(BAND) < 32'(last_avg))
        last_avg = TEMP_W'(mean & HALF_MASK);
      res.avg_temp  = last_avg;
      res.avg_valid = 1'b1;
    end
    avg_expected.push_back(res);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR: %s", $time, msg);
    n_mismatch++;
  endtask

  task automatic send_sample(input logic [CODE_W-1:0] code, input logic rep);
    int gap;
    in_ch.adc_code <= code;
    in_ch.report   <= rep;
    in_ch.valid    <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    model_sample(code, rep);
    n_samples++;
    @(negedge clk);
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TEMP_W-1:0] data);
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_MIN_TEMP)
      min_lim = data;
    else if (idx == REG_MAX_TEMP)
      max_lim = data;
    n_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_window(input int lo, input int hi);
    write_reg(REG_MIN_TEMP, TEMP_W'(lo));
    write_reg(REG_MAX_TEMP, TEMP_W'(hi));
  endtask

  // Stop offering samples, wait for every queued average, then let any
  // non-reporting sample still in flight finish.
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (avg_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic test_reset_window();
    send_sample(16'd0, 1'b1);        // nothing in range yet: invalid
    send_sample(16'd400, 1'b1);      // exactly min_temp
    send_sample(16'd399, 1'b0);      // one step below min_temp
    send_sample(16'd29971, 1'b1);    // exactly max_temp
    send_sample(16'd29972, 1'b0);    // one step above max_temp
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hAAAA, 1'b1);
    send_sample(16'h5555, 1'b1);
  endtask

  task automatic test_hysteresis_steps();
    quiesce();
    set_window(0, TEMP_TOP);         // cleared entries now count
    send_sample(16'd0, 1'b1);        // large drop: round down
    send_sample(16'd0, 1'b1);        // inside the band: hold
    send_sample(16'd60000, 1'b1);    // large rise: round up
    send_sample(16'd100, 1'b1);
  endtask

  task automatic test_register_extremes();
    quiesce();
    set_window(0, 0);                // only zero entries qualify
    send_sample(16'd0, 1'b1);
    send_sample(16'd1, 1'b1);
    quiesce();
    set_window(TEMP_TOP, TEMP_TOP);  // top code scales just below this
    send_sample(16'hFFFF, 1'b1);
    quiesce();
    set_window(40000, 1000);         // min above max
    send_sample(16'd20000, 1'b1);
    send_sample(16'd1000, 1'b1);
    quiesce();
    write_reg(REG_UNUSED_2, '1);
    write_reg(REG_UNUSED_3, '0);
    send_sample(16'd30000, 1'b1);
    quiesce();
    set_window(0, TEMP_TOP);
    send_sample(16'hFFFF, 1'b1);
  endtask

  task automatic test_backpressure();
    quiesce();
    in_gaps_on = 1'b0;
    long_hold  = LONG_HOLD;
    repeat (2) @(negedge clk);
    for (int i = 0; i < 10; i++)
      send_sample(CODE_W'($urandom), (i % 3) != 1);
    quiesce();
    in_gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    window_kind_t kind;
    int           lo_t;
    int           hi_t;
    int           lo_code;
    int           hi_code;
    int           walk;
    logic [CODE_W-1:0] code;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      quiesce();
      if (ph == 0)
        kind = WIN_RESET;
      else if (ph == 1)
        kind = WIN_FULL;
      else if (ph == 2)
        kind = WIN_INVERTED;
      else if (ph == 3)
        kind = WIN_NARROW;
      else if (ph == 4)
        kind = WIN_WIDE;
      else
        kind = window_kind_t'($urandom_range(0, 4));
      unique case (kind)
        WIN_RESET: begin
          lo_t = MIN_TEMP_RST;
          hi_t = MAX_TEMP_RST;
        end
        WIN_FULL: begin
          lo_t = 0;
          hi_t = TEMP_TOP;
        end
        WIN_NARROW: begin
          lo_t = $urandom_range(0, TEMP_TOP);
          hi_t = lo_t + $urandom_range(0, 4000);
        end
        WIN_INVERTED: begin
          hi_t = $urandom_range(0, TEMP_TOP - 1);
          lo_t = $urandom_range(hi_t + 1, TEMP_TOP);
        end
        default: begin
          lo_t = $urandom_range(0, 20000);
          hi_t = $urandom_range(30000, TEMP_TOP);
        end
      endcase
      if (hi_t > TEMP_TOP) hi_t = TEMP_TOP;
      set_window(lo_t, hi_t);
      if (kind == WIN_INVERTED) begin
        lo_code = 0;
        hi_code = 65535;
      end else begin
        lo_code = lo_t * 256 / 328;
        hi_code = hi_t * 256 / 328 + 1;
        if (hi_code > 65535) hi_code = 65535;
      end
      in_gaps_on  = !(ph == 1 || ph == 4);
      out_gaps_on = !(ph == 1 || ph == 5);
      walk = $urandom_range(lo_code, hi_code);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // slow drift with occasional jumps keeps the average moving across the band
        if ($urandom_range(0, 49) == 0)
          walk = $urandom_range(lo_code, hi_code);
        else
          walk += int'($urandom_range(0, 40)) - 20;
        if (walk < lo_code) walk = lo_code;
        if (walk > hi_code) walk = hi_code;
        if ($urandom_range(0, 9) == 0)
          code = CODE_W'($urandom);
        else
          code = CODE_W'(walk);
        send_sample(code, $urandom_range(0, 3) == 0);
      end
    end
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  // result receiver: random stalls plus the long hold-off on request
  initial begin : result_drain
    int stall;
    out_ch.ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        stall = long_hold;
        long_hold = 0;
      end else if (stall == 0 && out_gaps_on && !rst) begin
        stall = pick_gap();
      end
      if (stall > 0 || rst) begin
        out_ch.ready <= 1'b0;
        if (stall > 0) stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    avg_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (!out_ch.avg_valid) n_invalid++;
      if (avg_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected average %0d valid %0b",
                                  out_ch.avg_temp, out_ch.avg_valid));
      end else begin
        want = avg_expected.pop_front();
        if (out_ch.avg_temp !== want.avg_temp)
          report_mismatch($sformatf("avg_temp %0d, expected %0d",
                                    out_ch.avg_temp, want.avg_temp));
        if (out_ch.avg_valid !== want.avg_valid)
          report_mismatch($sformatf("avg_valid %0b, expected %0b",
                                    out_ch.avg_valid, want.avg_valid));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ERROR: no transaction for %0d cycles, %0d averages outstanding",
               $time, idle_cycles, avg_expected.size());
      $display("temp_ring_average_hysteresis_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst            = 1'b1;
    in_ch.valid    = 1'b0;
    in_ch.adc_code = '0;
    in_ch.report   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_MIN_TEMP;
    cfg_ch.data    = '0;
    idle_cycles    = 0;
    long_hold      = 0;
    in_gaps_on     = 1'b1;
    out_gaps_on    = 1'b1;
    n_samples      = 0;
    n_results      = 0;
    n_invalid      = 0;
    n_writes       = 0;
    n_mismatch     = 0;
    min_lim        = MIN_TEMP_RST;
    max_lim        = MAX_TEMP_RST;
    wr_pos         = 0;
    last_avg       = '0;
    for (int i = 0; i < RING_DEPTH; i++) ring[i] = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_window();
    test_hysteresis_steps();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();
    quiesce();

    $display("covered %0d samples and %0d averages (%0d with no entry in range)",
             n_samples, n_results, n_invalid);
    $display("over %0d register writes: reset, full, narrow, wide and inverted windows",
             n_writes);
    if (n_mismatch == 0)
      $display("temp_ring_average_hysteresis_unit: match");
    else
      $display("temp_ring_average_hysteresis_unit: mismatch");
    $finish;
  end

endmodule

>>> temp_ring_average_hysteresis_unit.f
rtl/trah_pkg.sv
rtl/trah_if.sv
rtl/trah_ctrl.sv
rtl/trah_dpath.sv
rtl/temp_ring_average_hysteresis_unit.sv
dv/tb_temp_ring_average_hysteresis_unit.sv
